// ===== rtl/bci_pkg.sv =====
`default_nettype none
package bci_pkg;

  localparam int NumLevels = 8;
  localparam int LevelW    = 8;
  localparam int PointW    = 3;
  localparam int CfgIdxW   = 4;
  localparam int RecipShift = 24;
  localparam int RecipW     = RecipShift + 1;

  typedef logic [NumLevels-1:0][LevelW-1:0] bci_level_arr_t;

  // entry 7 first in the packed literal
  localparam bci_level_arr_t LevelReset = {
    8'd255, 8'd218, 8'd182, 8'd145, 8'd109, 8'd72, 8'd36, 8'd0
  };

  // classified item handed from the front to the back
  typedef struct packed {
    logic              preview;
    logic [PointW-1:0] point;   // curve point in preview, segment otherwise
    logic [7:0]        offset;  // distance from the segment's lower bound
  } bci_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/brightness_curve_interpolator.sv =====
// path: an accepted item is held in the queue, then passes the stage-1, stage-2 and output registers with its strobe
// throughput: one item per cycle while busy is low; the back pipeline drains the queue every cycle,
// so busy stays low in normal use and the queue only parts front from back
// reset: curve levels return to their defaults, queue and pipeline empty
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none
module brightness_curve_interpolator #(
  parameter int POINTS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [7:0]                  light_level_i,
  input  wire logic [7:0]                  pot_position_i,
  input  wire logic [3:0]                  preview_point_i,
  output logic                             result_valid_o,
  output logic [7:0]                       brightness_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bci_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i
);
  import bci_pkg::*;

  bci_level_arr_t levels_q, levels_d;
  bci_cmd_t       front_cmd, queue_cmd;
  logic           q_empty, q_full;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  always_comb begin
    levels_d = levels_q;
    if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumLevels))) begin
      levels_d[cfg_index_i[PointW-1:0]] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LevelReset;
    end else begin
      levels_q <= levels_d;
    end
  end

  bci_front #(.POINTS(POINTS)) u_front (
    .light_level_i  (light_level_i),
    .pot_position_i (pot_position_i),
    .preview_point_i(preview_point_i),
    .cmd_o          (front_cmd)
  );

  bci_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start && !q_full),
    .push_data_i(front_cmd),
    .pop_i      (!q_empty),
    .pop_data_o (queue_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  bci_back #(.POINTS(POINTS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_empty),
    .cmd_i         (queue_cmd),
    .levels_i      (levels_q),
    .result_valid_o(result_valid_o),
    .brightness_o  (brightness_o)
  );

endmodule
`default_nettype wire

// ===== rtl/bci_front.sv =====
`default_nettype none
module bci_front #(
  parameter int POINTS = 8
) (
  input  wire logic [7:0]       light_level_i,
  input  wire logic [7:0]       pot_position_i,
  input  wire logic [3:0]       preview_point_i,
  output bci_pkg::bci_cmd_t     cmd_o
);
  import bci_pkg::*;

  logic [9:0]        sum;
  logic [7:0]        corr;
  logic [NumLevels-1:0][7:0] hi_bound;
  logic [NumLevels-1:0][7:0] lo_bound;
  logic [NumLevels-1:0]      above;
  logic [PointW-1:0] seg;
  logic [PointW-1:0] prev_idx;

  for (genvar g = 0; g < NumLevels; g++) begin : g_bound
    if (g < POINTS - 1) begin : g_used
      localparam int HiB = (255 * (g + 1)) / (POINTS - 1);
      localparam int LoB = (255 * g) / (POINTS - 1);
      assign hi_bound[g] = 8'(HiB);
      assign lo_bound[g] = 8'(LoB);
    end else begin : g_unused
      assign hi_bound[g] = 8'd255;
      assign lo_bound[g] = 8'd0;
    end
  end

  always_comb begin
    sum = {2'b00, light_level_i} + {2'b00, pot_position_i} - 10'd127;
    if (sum[9]) begin
      corr = 8'd0;
    end else if (sum[8]) begin
      corr = 8'd255;
    end else begin
      corr = sum[7:0];
    end
  end

  // segment is the number of upper bounds lying strictly below the value
  always_comb begin
    seg = '0;
    for (int i = 0; i < NumLevels; i++) begin
      above[i] = (i < POINTS - 1) && (hi_bound[i] < corr);
      seg = seg + PointW'(above[i]);
    end
  end

  always_comb begin
    if (preview_point_i > 4'(POINTS)) begin
      prev_idx = PointW'(POINTS - 1);
    end else begin
      prev_idx = PointW'(preview_point_i - 4'd1);
    end
  end

  always_comb begin
    cmd_o.preview = (preview_point_i != 4'd0);
    cmd_o.point   = cmd_o.preview ? prev_idx : seg;
    cmd_o.offset  = corr - lo_bound[seg];
  end

endmodule
`default_nettype wire

// ===== rtl/bci_queue.sv =====
`default_nettype none
module bci_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bci_pkg::bci_cmd_t push_data_i,
  input  wire logic              pop_i,
  output bci_pkg::bci_cmd_t      pop_data_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import bci_pkg::*;

  bci_cmd_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign empty_o    = (cnt_q == 2'd0);
  assign full_o     = (cnt_q == 2'd2);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bci_back.sv =====
`default_nettype none
module bci_back #(
  parameter int POINTS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cmd_valid_i,
  input  wire bci_pkg::bci_cmd_t       cmd_i,
  input  wire bci_pkg::bci_level_arr_t levels_i,
  output logic                         result_valid_o,
  output logic [7:0]                   brightness_o
);
  import bci_pkg::*;

  logic [NumLevels-1:0][RecipW-1:0] recip_tab;

  // stage 1: level lookup and slope product
  logic [7:0]        lo_lvl, hi_lvl;
  logic signed [8:0] diff, off_s;
  logic signed [17:0] prod_d, prod_q;
  logic              v1_q;
  logic [7:0]        lo1_q;
  logic [PointW-1:0] seg1_q;

  // stage 2: divide by segment span via reciprocal
  logic [17:0]       neg_p;
  logic [15:0]       mag;
  logic [40:0]       wide;
  logic              v2_q;
  logic [7:0]        lo2_q, quo_q;
  logic              neg2_q;

  logic [7:0]        res_d;

  for (genvar g = 0; g < NumLevels; g++) begin : g_recip
    if (g < POINTS - 1) begin : g_used
      localparam int Span  = (255 * (g + 1)) / (POINTS - 1) - (255 * g) / (POINTS - 1);
      localparam int SpanS = (Span == 0) ? 1 : Span;
      localparam int Recip = ((1 << RecipShift) + SpanS - 1) / SpanS;
      assign recip_tab[g] = RecipW'(Recip);
    end else begin : g_unused
      assign recip_tab[g] = '0;
    end
  end

  always_comb begin
    lo_lvl = levels_i[cmd_i.point];
    hi_lvl = levels_i[PointW'(cmd_i.point + PointW'(1))];
    diff   = cmd_i.preview ? 9'sd0 : $signed({1'b0, hi_lvl} - {1'b0, lo_lvl});
    off_s  = $signed({1'b0, cmd_i.offset});
    prod_d = off_s * diff;
  end

  always_comb begin
    neg_p = 18'(-prod_q);
    mag   = prod_q[17] ? neg_p[15:0] : prod_q[15:0];
    wide  = {25'b0, mag} * {16'b0, recip_tab[seg1_q]};
    res_d = neg2_q ? (lo2_q - quo_q) : (lo2_q + quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      v1_q           <= cmd_valid_i;
      v2_q           <= v1_q;
      result_valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    lo1_q        <= lo_lvl;
    seg1_q       <= cmd_i.point;
    quo_q        <= wide[RecipShift+7:RecipShift];
    neg2_q       <= prod_q[17];
    lo2_q        <= lo1_q;
    brightness_o <= res_d;
  end

endmodule
`default_nettype wire
